// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");

// Clocked property, checked in every cycle including reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("property violated");

`endif

// File: hw/rtl/c2d_pkg.sv
// Types and constants for the conv2d block: beat structs, codes, FSM states.
// No dependencies.
package c2d_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;

  typedef enum logic [1:0] {
    OP_WRITE_FEATURE = 2'd0,
    OP_WRITE_WEIGHT  = 2'd1,
    OP_WRITE_BIAS    = 2'd2,
    OP_COMPUTE       = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAP_HEIGHT  = 3'd0,
    REG_MAP_WIDTH   = 3'd1,
    REG_IN_CHANNELS = 3'd2,
    REG_OUT_FILTERS = 3'd3,
    REG_KERNEL_ROWS = 3'd4,
    REG_KERNEL_COLS = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_FLUSH
  } state_t;

  localparam logic [5:0] RST_MAP_HEIGHT  = 6'd32;
  localparam logic [5:0] RST_MAP_WIDTH   = 6'd32;
  localparam logic [4:0] RST_IN_CHANNELS = 5'd16;
  localparam logic [4:0] RST_OUT_FILTERS = 5'd16;
  localparam logic [2:0] RST_KERNEL_ROWS = 3'd3;
  localparam logic [2:0] RST_KERNEL_COLS = 3'd3;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    op_t                op;
    logic [13:0]        store_index;
    logic signed [15:0] write_value;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic [3:0]         out_filter;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic setup;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/c2d_ctrl.sv
// Sequencer for the conv2d block: accepts beats, steps the tap loop, loads results.
// Depends on c2d_pkg.
module c2d_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  c2d_pkg::status_t status,
  output c2d_pkg::cmd_t    cmd
);

  c2d_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      c2d_pkg::ST_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
        if (in_valid && !rst && status.hit) begin
          cmd.start  = 1'b1;
          state_next = c2d_pkg::ST_SETUP;
        end
      end
      c2d_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = c2d_pkg::ST_RUN;
      end
      c2d_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_tap) begin
          state_next = c2d_pkg::ST_FLUSH;
        end
      end
      c2d_pkg::ST_FLUSH: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.load   = 1'b1;
          state_next = c2d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = c2d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/c2d_datapath.sv
// Datapath of the conv2d block: config registers, three stores, tap address
// walk, multiply-accumulate pipeline and result register. Depends on c2d_pkg.
module c2d_datapath #(
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_KERNEL   = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [c2d_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  c2d_pkg::in_item_t                in_item,
  input  c2d_pkg::cmd_t                    cmd,
  output c2d_pkg::status_t                 status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output c2d_pkg::out_item_t               out_item
);

  localparam int FEAT_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
  localparam int WGT_DEPTH  = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS * MAX_FILTERS;
  localparam int BIAS_DEPTH = MAX_FILTERS;
  localparam int FA_W = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BA_W = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
  localparam int TAPS  = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int ACC_W = 33 + $clog2(TAPS + 1);

  localparam logic [5:0] H_MAX = (MAX_HEIGHT > 63) ? 6'd63 : 6'(MAX_HEIGHT);
  localparam logic [5:0] W_MAX = (MAX_WIDTH > 63) ? 6'd63 : 6'(MAX_WIDTH);
  localparam logic [4:0] C_MAX = (MAX_CHANNELS > 31) ? 5'd31 : 5'(MAX_CHANNELS);
  localparam logic [4:0] F_MAX = (MAX_FILTERS > 31) ? 5'd31 : 5'(MAX_FILTERS);
  localparam logic [2:0] K_MAX = (MAX_KERNEL > 7) ? 3'd7 : 3'(MAX_KERNEL);

  // configuration registers
  logic [5:0] reg_height, reg_width;
  logic [4:0] reg_channels, reg_filters;
  logic [2:0] reg_krows, reg_kcols;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_height   <= c2d_pkg::RST_MAP_HEIGHT;
      reg_width    <= c2d_pkg::RST_MAP_WIDTH;
      reg_channels <= c2d_pkg::RST_IN_CHANNELS;
      reg_filters  <= c2d_pkg::RST_OUT_FILTERS;
      reg_krows    <= c2d_pkg::RST_KERNEL_ROWS;
      reg_kcols    <= c2d_pkg::RST_KERNEL_COLS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2d_pkg::REG_MAP_HEIGHT:  reg_height   <= cfg_data;
        c2d_pkg::REG_MAP_WIDTH:   reg_width    <= cfg_data;
        c2d_pkg::REG_IN_CHANNELS: reg_channels <= cfg_data[4:0];
        c2d_pkg::REG_OUT_FILTERS: reg_filters  <= cfg_data[4:0];
        c2d_pkg::REG_KERNEL_ROWS: reg_krows    <= cfg_data[2:0];
        c2d_pkg::REG_KERNEL_COLS: reg_kcols    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  logic [5:0] h, w;
  logic [4:0] c, f;
  logic [2:0] kr, kc;

  always_comb begin
    h  = (reg_height == 6'd0) ? 6'd1 : ((reg_height > H_MAX) ? H_MAX : reg_height);
    w  = (reg_width == 6'd0) ? 6'd1 : ((reg_width > W_MAX) ? W_MAX : reg_width);
    c  = (reg_channels == 5'd0) ? 5'd1 : ((reg_channels > C_MAX) ? C_MAX : reg_channels);
    f  = (reg_filters == 5'd0) ? 5'd1 : ((reg_filters > F_MAX) ? F_MAX : reg_filters);
    kr = (reg_krows == 3'd0) ? 3'd1 : ((reg_krows > K_MAX) ? K_MAX : reg_krows);
    kc = (reg_kcols == 3'd0) ? 3'd1 : ((reg_kcols > K_MAX) ? K_MAX : reg_kcols);
  end

  // window origin of the item on the input
  logic signed [7:0]  ii_start, jj_start;
  logic signed [15:0] pos_start;

  assign ii_start  = $signed({3'b000, in_item.out_row}) - $signed({6'b0, kr[2:1]});
  assign jj_start  = $signed({3'b000, in_item.out_col}) - $signed({6'b0, kc[2:1]});
  assign pos_start = ii_start * $signed({2'b00, w}) + 16'(jj_start);

  // tap walk
  logic signed [15:0] pos;
  logic signed [21:0] base_prod;
  logic [10:0]        wc;
  logic [FA_W-1:0]    fa, row_base;
  logic [WA_W-1:0]    wa;
  logic signed [7:0]  ii, jj, jj0;
  logic [2:0]         ki, kj;
  logic [4:0]         ci;
  logic               tap_ok, last_ci, last_kj, last_ki;

  assign base_prod = pos * $signed({1'b0, c});
  assign tap_ok  = (ii >= 8'sd0) && (ii < $signed({2'b00, h}))
                && (jj >= 8'sd0) && (jj < $signed({2'b00, w}));
  assign last_ci = (ci == c - 5'd1);
  assign last_kj = (kj == kc - 3'd1);
  assign last_ki = (ki == kr - 3'd1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos <= pos_start;
      wc  <= 11'(w * c);
      ii  <= ii_start;
      jj  <= jj_start;
      jj0 <= jj_start;
      ki  <= 3'd0;
      kj  <= 3'd0;
      ci  <= 5'd0;
      wa  <= WA_W'(in_item.out_filter);
    end else if (cmd.setup) begin
      fa       <= FA_W'(base_prod);
      row_base <= FA_W'(base_prod);
    end else if (cmd.step) begin
      wa <= wa + WA_W'(f);
      if (!last_ci) begin
        ci <= ci + 5'd1;
        fa <= fa + FA_W'(1);
      end else begin
        ci <= 5'd0;
        if (!last_kj) begin
          kj <= kj + 3'd1;
          jj <= jj + 8'sd1;
          fa <= fa + FA_W'(1);
        end else begin
          kj       <= 3'd0;
          jj       <= jj0;
          ki       <= ki + 3'd1;
          ii       <= ii + 8'sd1;
          fa       <= row_base + FA_W'(wc);
          row_base <= row_base + FA_W'(wc);
        end
      end
    end
  end

  // stores
  logic [15:0] feat_mem [FEAT_DEPTH];
  logic [15:0] wgt_mem  [WGT_DEPTH];
  logic [15:0] bias_mem [BIAS_DEPTH];
  logic [15:0] feat_q, wgt_q, bias_q;
  logic        wr_feat, wr_wgt, wr_bias;

  assign wr_feat = cmd.accept && (in_item.op == c2d_pkg::OP_WRITE_FEATURE)
                && (32'(in_item.store_index) < FEAT_DEPTH);
  assign wr_wgt  = cmd.accept && (in_item.op == c2d_pkg::OP_WRITE_WEIGHT)
                && (32'(in_item.store_index) < WGT_DEPTH);
  assign wr_bias = cmd.accept && (in_item.op == c2d_pkg::OP_WRITE_BIAS)
                && (32'(in_item.store_index) < BIAS_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_feat) begin
      feat_mem[FA_W'(in_item.store_index)] <= in_item.write_value;
    end
    if (cmd.step) begin
      feat_q <= feat_mem[fa];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_wgt) begin
      wgt_mem[WA_W'(in_item.store_index)] <= in_item.write_value;
    end
    if (cmd.step) begin
      wgt_q <= wgt_mem[wa];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_bias) begin
      bias_mem[BA_W'(in_item.store_index)] <= in_item.write_value;
    end
    if (cmd.start) begin
      bias_q <= bias_mem[BA_W'(in_item.out_filter)];
    end
  end

  // multiply-accumulate pipeline
  logic               v1, v2;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.step && tap_ok;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(feat_q) * $signed(wgt_q);
    if (cmd.setup) begin
      acc <= ACC_W'($signed(bias_q)) <<< 8;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // saturate and hold the result
  logic [ACC_W-32:0] acc_hi;
  logic              sat;
  logic [31:0]       sat_value;

  assign acc_hi    = acc[ACC_W-1:31];
  assign sat       = !((&acc_hi) || !(|acc_hi));
  assign sat_value = acc[ACC_W-1] ? c2d_pkg::SAT_MIN : c2d_pkg::SAT_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_item.result_value <= sat ? sat_value : acc[31:0];
      out_item.saturated    <= sat;
    end
  end

  always_comb begin
    status.hit = (in_item.op == c2d_pkg::OP_COMPUTE)
              && ({1'b0, in_item.out_row} < h)
              && ({1'b0, in_item.out_col} < w)
              && ({1'b0, in_item.out_filter} < f);
    status.last_tap  = last_ci && last_kj && last_ki;
    status.pipe_busy = v1 || v2;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/conv2d_same_padding.sv
// Top level of the 2-D same-padded convolution block with per-filter bias.
// Depends on c2d_pkg, c2d_ctrl and c2d_datapath.
//
// Input channel (in_valid/in_ready/in_item): each beat either writes one
// Q8.8 value into the feature, weight or bias store, or asks for one output
// (row, column, filter). Configuration writes (cfg_we/cfg_index/cfg_data)
// are registered; the user must make them only while the block is idle,
// which the block itself does not enforce. A write beat leaves the block
// idle with in_ready high for the next beat. A compute beat walks
// kernel_rows * kernel_cols * in_channels taps, one multiply-accumulate
// per cycle, bounded by the single read port of the feature and weight
// stores, then flushes the pipeline before the result is loaded and the
// next beat is taken; in_ready stays low during that walk.
// A compute beat outside the map or filter range is accepted and dropped.
// Output channel (out_valid/out_ready/out_item): Q16.16 sum plus bias,
// saturated to 32 bits with a flag. The result register lets the next beat
// in while a result waits; a finished walk holds until that register frees.
// Reset clears the sequencer and the result valid, sets the config registers
// to their defaults and holds in_ready low; the stores are undefined until written.
module conv2d_same_padding #(
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_KERNEL   = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [c2d_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  c2d_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output c2d_pkg::out_item_t               out_item
);

  c2d_pkg::cmd_t    cmd;
  c2d_pkg::status_t status;

  c2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  c2d_datapath #(
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FILTERS  (MAX_FILTERS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: hw/rtl/c2d_checker.sv
// Port-level checks for conv2d_same_padding, attached by bind.
// Depends on c2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module c2d_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input c2d_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input c2d_pkg::out_item_t out_item
);

  `ASSERT_CLK(a_reset_clears_out, clk, rst |=> !out_valid)

  `ASSERT_CLK_RST(a_write_keeps_ready, clk, rst,
    (in_valid && in_ready && (in_item.op != c2d_pkg::OP_COMPUTE)) |=> in_ready)

  `ASSERT_CLK_RST(a_result_after_walk, clk, rst, $rose(out_valid) |-> !$past(in_ready))

  `ASSERT_CLK_RST(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))

endmodule

bind conv2d_same_padding c2d_checker u_c2d_checker (.*);
